@@ rtl/core/rrhr_pkg.sv @@
// Shared types and constants for the R-R interval heart rate median block.
`default_nettype none

package rrhr_pkg;

    localparam int unsigned HISTORY_DEPTH = 7;
    localparam int unsigned FILL_W        = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned IDX_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned RATE_W   = 12;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned COUNT_W  = 3;
    localparam int unsigned MIN_W    = 16;
    localparam int unsigned LIMIT_W  = 4;
    localparam int unsigned BPM_W    = 8;
    localparam int unsigned NOISE_W  = 5;
    localparam int unsigned PROD_W   = BPM_W + TIME_W;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_RATE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_RATE    = 2'd3;

    localparam logic [MIN_W-1:0]   MIN_INTERVAL_RST = 16'd300;
    localparam logic [LIMIT_W-1:0] NOISE_LIMIT_RST  = 4'd3;
    localparam logic [BPM_W-1:0]   LOW_RATE_RST     = 8'd30;
    localparam logic [BPM_W-1:0]   HIGH_RATE_RST    = 8'd220;

    localparam logic [STATUS_W-1:0] STS_FIRST  = 3'd0;
    localparam logic [STATUS_W-1:0] STS_ACCEPT = 3'd1;
    localparam logic [STATUS_W-1:0] STS_NOISE  = 3'd2;
    localparam logic [STATUS_W-1:0] STS_NRESET = 3'd3;
    localparam logic [STATUS_W-1:0] STS_RANGE  = 3'd4;

    // ms per minute, and the same scaled by 16 for the Q4 rate
    localparam logic [PROD_W-1:0] MS_PER_MIN = PROD_W'(60000);
    localparam int unsigned       DIV_BITS   = 20;
    localparam int unsigned       DIV_CNT_W  = $clog2(DIV_BITS);
    localparam logic [DIV_BITS-1:0] RATE_DIVIDEND = DIV_BITS'(960000);

    typedef struct packed {
        logic                in_load;
        logic                first;
        logic                noise_inc;
        logic                noise_clr;
        logic                clear_all;
        logic                mul;
        logic                div_start;
        logic                div_step;
        logic                push;
        logic                med_step;
        logic                out_load;
        logic [STATUS_W-1:0] status;
    } t_dp_cmd;

    typedef struct packed {
        logic have_peak;
        logic is_noise;
        logic noise_over;
        logic out_range;
        logic div_done;
        logic med_last;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ rtl/core/rrhr_ctrl.sv @@
// Sequencer for peak classification, rate division and median scan.
`default_nettype none

module rrhr_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    input  wire rrhr_pkg::t_dp_sts i_sts,
    output rrhr_pkg::t_dp_cmd o_cmd
);
    import rrhr_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLASS = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_RANGE = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_PUSH  = 3'd5;
    localparam logic [2:0] ST_MED   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0]          r_state,     n_state;
    logic [STATUS_W-1:0] r_status,    n_status;
    logic                r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd        = '0;
        o_cmd.status = r_status;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.in_load = 1'b1;
                    n_state       = ST_CLASS;
                end
            end
            ST_CLASS: begin
                if (!i_sts.have_peak) begin
                    o_cmd.first = 1'b1;
                    n_status    = STS_FIRST;
                    n_state     = ST_OUT;
                end else if (i_sts.is_noise) begin
                    o_cmd.noise_inc = 1'b1;
                    if (i_sts.noise_over) begin
                        o_cmd.clear_all = 1'b1;
                        n_status        = STS_NRESET;
                    end else begin
                        n_status = STS_NOISE;
                    end
                    n_state = ST_OUT;
                end else begin
                    o_cmd.noise_clr = 1'b1;
                    n_state         = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_RANGE;
            end
            ST_RANGE: begin
                if (i_sts.out_range) begin
                    n_status = STS_RANGE;
                    n_state  = ST_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = ST_MED;
            end
            ST_MED: begin
                o_cmd.med_step = 1'b1;
                if (i_sts.med_last) begin
                    n_status = STS_ACCEPT;
                    n_state  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_status    <= STS_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ rtl/core/rrhr_dp.sv @@
// Datapath: settings, peak state, range check, rate divider, history and median.
`default_nettype none

module rrhr_dp (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_valid,
    input  wire  [rrhr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [rrhr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire  [rrhr_pkg::TIME_W-1:0]     i_peak_time_ms,
    input  wire  rrhr_pkg::t_dp_cmd         i_cmd,
    output rrhr_pkg::t_dp_sts              o_sts,
    output logic [rrhr_pkg::RATE_W-1:0]     o_heart_rate_q4,
    output logic [rrhr_pkg::STATUS_W-1:0]   o_status,
    output logic [rrhr_pkg::COUNT_W-1:0]    o_history_count
);
    import rrhr_pkg::*;

    logic [MIN_W-1:0]   r_min_interval;
    logic [LIMIT_W-1:0] r_noise_limit;
    logic [BPM_W-1:0]   r_low_rate;
    logic [BPM_W-1:0]   r_high_rate;

    logic                r_have_peak;
    logic [TIME_W-1:0]   r_last;
    logic [TIME_W-1:0]   r_time;
    logic [NOISE_W-1:0]  r_noise;
    logic [TIME_W-1:0]   r_interval;
    logic [PROD_W-1:0]   r_lo_prod;
    logic [PROD_W-1:0]   r_hi_prod;
    logic [DIV_BITS-1:0] r_rem;
    logic [RATE_W-1:0]   r_quo;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [RATE_W-1:0]   r_hist [HISTORY_DEPTH];
    logic [FILL_W-1:0]   r_fill;
    logic [IDX_W-1:0]    r_med_idx;
    logic [RATE_W-1:0]   r_median;

    logic [RATE_W-1:0]   r_o_rate;
    logic [STATUS_W-1:0] r_o_status;
    logic [FILL_W-1:0]   r_o_fill;

    logic [TIME_W-1:0]   interval;
    logic [NOISE_W-1:0]  noise_inc;
    logic [DIV_BITS:0]   rem_sh;
    logic [TIME_W-1:0]   rem_ext;
    logic [TIME_W-1:0]   rem_diff;
    logic                rem_ge;
    logic [RATE_W-1:0]   cand;
    logic [FILL_W-1:0]   cnt_lt;
    logic [FILL_W-1:0]   cnt_le;
    logic [FILL_W-1:0]   med_k;
    logic                med_hit;
    logic                hist_full;
    logic [FILL_W+2:0]   fill_ext;

    assign interval  = r_time - r_last;
    assign noise_inc = r_noise + NOISE_W'(1);

    assign rem_sh   = {r_rem, RATE_DIVIDEND[r_div_cnt]};
    assign rem_ext  = TIME_W'(rem_sh);
    assign rem_ge   = (rem_ext >= r_interval);
    assign rem_diff = rem_ext - r_interval;

    assign hist_full = (r_fill >= FILL_W'(HISTORY_DEPTH));
    assign cand      = r_hist[r_med_idx];
    assign med_k     = r_fill >> 1;

    always_comb begin
        cnt_lt = '0;
        cnt_le = '0;
        for (int j = 0; j < HISTORY_DEPTH; j++) begin
            if (FILL_W'(j) < r_fill) begin
                if (r_hist[j] < cand) begin
                    cnt_lt = cnt_lt + FILL_W'(1);
                end
                if (r_hist[j] <= cand) begin
                    cnt_le = cnt_le + FILL_W'(1);
                end
            end
        end
    end

    assign med_hit = (cnt_lt <= med_k) && (med_k < cnt_le);

    assign o_sts.have_peak  = r_have_peak;
    assign o_sts.is_noise   = (interval < TIME_W'(r_min_interval));
    assign o_sts.noise_over = (noise_inc > NOISE_W'(r_noise_limit));
    assign o_sts.out_range  = (r_interval == '0) || (r_lo_prod > MS_PER_MIN) ||
                              (r_hi_prod < MS_PER_MIN);
    assign o_sts.div_done   = (r_div_cnt == '0);
    assign o_sts.med_last   = (FILL_W'(r_med_idx) == (r_fill - FILL_W'(1)));

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_interval <= MIN_INTERVAL_RST;
            r_noise_limit  <= NOISE_LIMIT_RST;
            r_low_rate     <= LOW_RATE_RST;
            r_high_rate    <= HIGH_RATE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_INTERVAL: r_min_interval <= i_cfg_data[MIN_W-1:0];
                CFG_NOISE_LIMIT:  r_noise_limit  <= i_cfg_data[LIMIT_W-1:0];
                CFG_LOW_RATE:     r_low_rate     <= i_cfg_data[BPM_W-1:0];
                CFG_HIGH_RATE:    r_high_rate    <= i_cfg_data[BPM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // peak state, noise run, fill and median
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_peak <= 1'b0;
            r_last      <= '0;
            r_noise     <= '0;
            r_fill      <= '0;
            r_median    <= '0;
        end else if (i_cmd.clear_all) begin
            r_have_peak <= 1'b0;
            r_last      <= '0;
            r_noise     <= '0;
            r_fill      <= '0;
            r_median    <= '0;
        end else begin
            if (i_cmd.first) begin
                r_have_peak <= 1'b1;
                r_last      <= r_time;
            end
            if (i_cmd.noise_inc) begin
                r_noise <= noise_inc;
            end
            if (i_cmd.noise_clr) begin
                r_noise <= '0;
            end
            if (i_cmd.push) begin
                r_last <= r_time;
                if (!hist_full) begin
                    r_fill <= r_fill + FILL_W'(1);
                end
            end
            if (i_cmd.med_step && med_hit) begin
                r_median <= cand;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_time <= i_peak_time_ms;
        end
        if (i_cmd.noise_clr) begin
            r_interval <= interval;
        end
        if (i_cmd.mul) begin
            r_lo_prod <= PROD_W'(r_low_rate) * PROD_W'(r_interval);
            r_hi_prod <= PROD_W'(r_high_rate) * PROD_W'(r_interval);
        end
        if (i_cmd.div_start) begin
            r_rem     <= '0;
            r_quo     <= '0;
            r_div_cnt <= DIV_CNT_W'(DIV_BITS - 1);
        end else if (i_cmd.div_step) begin
            r_rem     <= rem_ge ? rem_diff[DIV_BITS-1:0] : rem_sh[DIV_BITS-1:0];
            r_quo     <= {r_quo[RATE_W-2:0], rem_ge};
            r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
        end
        if (i_cmd.push) begin
            r_med_idx <= '0;
            if (hist_full) begin
                for (int j = 0; j < HISTORY_DEPTH - 1; j++) begin
                    r_hist[j] <= r_hist[j+1];
                end
                r_hist[HISTORY_DEPTH-1] <= r_quo;
            end else begin
                r_hist[r_fill[IDX_W-1:0]] <= r_quo;
            end
        end else if (i_cmd.med_step) begin
            r_med_idx <= r_med_idx + IDX_W'(1);
        end
        if (i_cmd.out_load) begin
            r_o_rate   <= r_median;
            r_o_status <= i_cmd.status;
            r_o_fill   <= r_fill;
        end
    end

    assign fill_ext        = {3'b000, r_o_fill};
    assign o_heart_rate_q4 = r_o_rate;
    assign o_status        = r_o_status;
    assign o_history_count = fill_ext[COUNT_W-1:0];

endmodule

`default_nettype wire

@@ rtl/core/rr_interval_heart_rate_median.sv @@
// Top level of the R-R interval heart rate median filter.
// A kept peak runs through the 20-step restoring rate divider and then the
// one-entry-per-cycle median scan over the history; first, noise, noise-reset
// and out-of-range peaks skip both. A new peak is taken only in the idle state,
// once the last result is loaded; a result waits in the output register.
// Reset: synchronous active low; clears peak state, history fill and median,
// and loads the register defaults.
`default_nettype none

module rr_interval_heart_rate_median (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire  [rrhr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [rrhr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire  [rrhr_pkg::TIME_W-1:0]     i_peak_time_ms,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic [rrhr_pkg::RATE_W-1:0]     o_heart_rate_q4,
    output logic [rrhr_pkg::STATUS_W-1:0]   o_status,
    output logic [rrhr_pkg::COUNT_W-1:0]    o_history_count
);
    import rrhr_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    rrhr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rrhr_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_peak_time_ms  (i_peak_time_ms),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_heart_rate_q4 (o_heart_rate_q4),
        .o_status        (o_status),
        .o_history_count (o_history_count)
    );

endmodule

`default_nettype wire

@@ rtl/core/rrhr_checker.sv @@
// Port-level checks on the result channel, bound to the top level.
`default_nettype none

module rrhr_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          o_out_valid,
    input wire                          i_out_ready,
    input wire [rrhr_pkg::RATE_W-1:0]   o_heart_rate_q4,
    input wire [rrhr_pkg::STATUS_W-1:0] o_status,
    input wire [rrhr_pkg::COUNT_W-1:0]  o_history_count
);
    import rrhr_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_heart_rate_q4) &&
        $stable(o_status) && $stable(o_history_count))
        else $error("result beat changed while stalled");

    a_nreset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STS_NRESET) |->
        (o_heart_rate_q4 == '0) && (o_history_count == '0))
        else $error("noise reset beat carries history");

    a_first_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STS_FIRST) |->
        (o_heart_rate_q4 == '0) && (o_history_count == '0))
        else $error("first peak beat with nonempty history");

    a_accept_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STS_ACCEPT) |-> (o_history_count != '0))
        else $error("accepted beat with empty history");

endmodule

bind rr_interval_heart_rate_median rrhr_checker u_rrhr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_heart_rate_q4 (o_heart_rate_q4),
    .o_status        (o_status),
    .o_history_count (o_history_count)
);

`default_nettype wire
